FILE: rtl/assert_macros.svh
// assertion macros used by key_id_whitelist_store
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define KWS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kws assertion failed");

// next-cycle implication, disabled during reset
`define KWS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kws assertion failed");

`endif

FILE: rtl/kws_pkg.sv
// shared types, codes and defaults for the key id whitelist store
// no dependencies
package kws_pkg;

   localparam int ACCESS_DEPTH_DEF = 64;
   localparam int KEY_WIDTH_DEF    = 64;
   localparam int MASTER_SLOTS_DEF = 4;
   localparam int CSR_INDEX_W      = 8;

   // commands
   localparam logic [1:0] CMD_CHECK  = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   // lookup kinds
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_ACCESS = 2'd1;
   localparam logic [1:0] KIND_MASTER = 2'd2;

   // result status
   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_PRESENT   = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MASTER_COUNT = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MASTER_ID_0  = 8'd1;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] key_id;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [5:0] match_index;
      logic [1:0] status;
      logic [6:0] access_count;
      logic       changed;
   } rsp_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] idx;
   } master_hit_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SHIFT,
      S_REPLY
   } state_type;

endpackage

FILE: rtl/key_id_whitelist_store.sv
// the result is valid after the scan, a decide step and a reply step that follow the
// input transfer; the scan stops at the first access match, else after all used entries
// a remove that hits adds a shift-down of the entries above the match before the reply
// one item at a time; the next transfer is taken the cycle after the result registers
// reset clears the entry count, the changed flag and the master registers; table
// contents are not cleared and entries past the count are never read
`include "assert_macros.svh"

module key_id_whitelist_store #(
   parameter int ACCESS_DEPTH = kws_pkg::ACCESS_DEPTH_DEF,
   parameter int KEY_WIDTH    = kws_pkg::KEY_WIDTH_DEF,
   parameter int MASTER_SLOTS = kws_pkg::MASTER_SLOTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  kws_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output kws_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [kws_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                     csr_wdata
);
   import kws_pkg::*;

   localparam int ADDR_W = (ACCESS_DEPTH > 1) ? $clog2(ACCESS_DEPTH) : 1;
   localparam int CNT_W  = $clog2(ACCESS_DEPTH + 1);

   logic [KEY_WIDTH-1:0] key;
   master_hit_type       master_hit;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [KEY_WIDTH-1:0] wr_data;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic [KEY_WIDTH-1:0] rd_data;

   kws_access_ram #(
      .DEPTH  (ACCESS_DEPTH),
      .WIDTH  (KEY_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   kws_csr #(
      .KEY_WIDTH    (KEY_WIDTH),
      .MASTER_SLOTS (MASTER_SLOTS)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .key        (key),
      .master_hit (master_hit)
   );

   kws_ctrl #(
      .ACCESS_DEPTH (ACCESS_DEPTH),
      .KEY_WIDTH    (KEY_WIDTH),
      .ADDR_W       (ADDR_W),
      .CNT_W        (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .key        (key),
      .master_hit (master_hit),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   `KWS_ASSERT_NXT(a_busy_after_transfer, clock, reset, req_valid && req_ready, !req_ready)
   `KWS_ASSERT_IMP(a_present_is_access, clock, reset,
      rsp_valid && rsp_data.status == ST_PRESENT, rsp_data.kind == KIND_ACCESS)
   `KWS_ASSERT_IMP(a_full_not_access, clock, reset,
      rsp_valid && rsp_data.status == ST_FULL, rsp_data.kind != KIND_ACCESS)
   `KWS_ASSERT_IMP(a_remove_miss_idle, clock, reset,
      rsp_valid && rsp_data.kind == KIND_NONE && rsp_data.status != ST_DONE,
      rsp_data.match_index == 6'd0)

endmodule

FILE: rtl/kws_access_ram.sv
// access key table: one write port, one read port, registered read data
// no package dependencies
module kws_access_ram #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/kws_csr.sv
// master key registers, their write port and the master id compare
// depends on kws_pkg
module kws_csr #(
   parameter int KEY_WIDTH    = 64,
   parameter int MASTER_SLOTS = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [kws_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [63:0]                        csr_wdata,
   input  logic [KEY_WIDTH-1:0]               key,
   output kws_pkg::master_hit_type            master_hit
);
   import kws_pkg::*;

   logic [2:0]           master_count_ff;
   logic [KEY_WIDTH-1:0] master_id_ff [MASTER_SLOTS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         master_count_ff <= '0;
      end else if (csr_valid && csr_index == CSR_MASTER_COUNT) begin
         master_count_ff <= csr_wdata[2:0];
      end
   end

   // slots past MASTER_SLOTS are never compared, so their writes are dropped
   always_ff @(posedge clock) begin
      for (int i = 0; i < MASTER_SLOTS; i++) begin
         if (reset) begin
            master_id_ff[i] <= '0;
         end else if (csr_valid && csr_index == CSR_MASTER_ID_0 + CSR_INDEX_W'(i)) begin
            master_id_ff[i] <= csr_wdata[KEY_WIDTH-1:0];
         end
      end
   end

   // walk down so the lowest matching slot wins
   always_comb begin
      master_hit = '0;
      for (int i = MASTER_SLOTS - 1; i >= 0; i--) begin
         if (3'(i) < master_count_ff && master_id_ff[i] == key) begin
            master_hit.hit = 1'b1;
            master_hit.idx = 2'(i);
         end
      end
   end

endmodule

FILE: rtl/kws_ctrl.sv
// sequencer: table scan, append, shift-down delete, result register
// depends on kws_pkg
module kws_ctrl #(
   parameter int ACCESS_DEPTH = 64,
   parameter int KEY_WIDTH    = 64,
   parameter int ADDR_W       = 6,
   parameter int CNT_W        = 7
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  kws_pkg::req_type        req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output kws_pkg::rsp_type        rsp_data,
   output logic [KEY_WIDTH-1:0]    key,
   input  kws_pkg::master_hit_type master_hit,
   output logic                    wr_en,
   output logic [ADDR_W-1:0]       wr_addr,
   output logic [KEY_WIDTH-1:0]    wr_data,
   output logic                    rd_en,
   output logic [ADDR_W-1:0]       rd_addr,
   input  logic [KEY_WIDTH-1:0]    rd_data
);
   import kws_pkg::*;

   state_type            state_ff, state_in;
   logic [1:0]           cmd_ff, cmd_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [CNT_W-1:0]     ptr_ff, ptr_in;
   logic                 pend_ff, pend_in;
   logic [ADDR_W-1:0]    pend_idx_ff, pend_idx_in;
   logic                 hit_ff, hit_in;
   logic [ADDR_W-1:0]    hit_idx_ff, hit_idx_in;
   logic [CNT_W-1:0]     used_ff, used_in;
   logic                 dirty_ff, dirty_in;
   rsp_type              res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 more;
   logic                 hit_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         used_ff      <= '0;
         dirty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         used_ff      <= used_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      ptr_ff      <= ptr_in;
      pend_idx_ff <= pend_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign more    = ptr_ff < used_ff;
   assign hit_now = pend_ff && rd_data == key_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      ptr_in       = ptr_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      used_in      = used_ff;
      dirty_in     = dirty_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = used_ff[ADDR_W-1:0];
      wr_data      = key_ff;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in   = req_data.command;
               key_in   = req_data.key_id[KEY_WIDTH-1:0];
               ptr_in   = '0;
               pend_in  = 1'b0;
               hit_in   = 1'b0;
               state_in = S_SCAN;
            end
         end

         // one read issued per cycle, the compare checks the registered data of the last read issued
         S_SCAN: begin
            if (hit_now) begin
               hit_in     = 1'b1;
               hit_idx_in = pend_idx_ff;
               pend_in    = 1'b0;
               state_in   = S_DECIDE;
            end else if (!more) begin
               pend_in  = 1'b0;
               state_in = S_DECIDE;
            end else begin
               rd_en       = 1'b1;
               ptr_in      = ptr_ff + CNT_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = ptr_ff[ADDR_W-1:0];
            end
         end

         S_DECIDE: begin
            res_in          = '0;
            state_in        = S_REPLY;
            if (hit_ff) begin
               res_in.kind        = KIND_ACCESS;
               res_in.match_index = 6'(hit_idx_ff);
            end else if (master_hit.hit) begin
               res_in.kind        = KIND_MASTER;
               res_in.match_index = 6'(master_hit.idx);
            end else begin
               res_in.kind        = KIND_NONE;
            end

            case (cmd_ff)
               CMD_ADD: begin
                  if (hit_ff) begin
                     res_in.status = ST_PRESENT;
                  end else if (used_ff >= CNT_W'(ACCESS_DEPTH)) begin
                     res_in.status = ST_FULL;
                  end else begin
                     wr_en              = 1'b1;
                     used_in            = used_ff + CNT_W'(1);
                     dirty_in           = 1'b1;
                     res_in.match_index = 6'(used_ff);
                     res_in.status      = ST_DONE;
                  end
               end
               CMD_REMOVE: begin
                  if (hit_ff) begin
                     res_in.status = ST_DONE;
                     dirty_in      = 1'b1;
                     ptr_in        = CNT_W'(hit_idx_ff) + CNT_W'(1);
                     pend_in       = 1'b0;
                     state_in      = S_SHIFT;
                  end else begin
                     res_in.status = ST_NOT_FOUND;
                  end
               end
               default: begin
                  res_in.status = (hit_ff || master_hit.hit) ? ST_DONE : ST_NOT_FOUND;
               end
            endcase
         end

         // read entry i+1, then write the registered read data to entry i
         S_SHIFT: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_idx_ff - ADDR_W'(1);
               wr_data = rd_data;
            end
            if (more) begin
               rd_en       = 1'b1;
               ptr_in      = ptr_ff + CNT_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = ptr_ff[ADDR_W-1:0];
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  used_in  = used_ff - CNT_W'(1);
                  state_in = S_REPLY;
               end
            end
         end

         S_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in              = res_ff;
               rsp_in.access_count = 7'(used_ff);
               rsp_in.changed      = dirty_ff;
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign key       = key_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
